[design/legendre_polynomial_eval_assert.svh]
// ---------------------------------------------------------------------------
// Legendre polynomial evaluator assertion macros
// Shared property macros for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef LEGENDRE_POLYNOMIAL_EVAL_ASSERT_SVH
`define LEGENDRE_POLYNOMIAL_EVAL_ASSERT_SVH

// Check a same-cycle implication, disabled during reset
`define LPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, disabled during reset
`define LPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lpe_pkg.sv]
// ---------------------------------------------------------------------------
// Legendre polynomial evaluator package
// Widths, constants, controller states and the division chain link types.
// ---------------------------------------------------------------------------
package lpe_pkg;

  // Field widths
  localparam int unsigned POINT_W  = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned DEGREE_W = 4;

  // Recurrence datapath widths
  localparam int unsigned PROD_W   = 18;  // (x * P) >>> 14
  localparam int unsigned SUM_W    = 24;  // (2k+1)*prod - k*prev
  localparam int unsigned QUOT_W   = 15;  // quotient magnitude below 2^15
  localparam int unsigned REM_W    = 19;  // divisor << 15 fits here
  localparam int unsigned Q_SHIFT  = 14;

  localparam logic [DEGREE_W-1:0]       MAX_DEGREE   = 4'd15;
  localparam logic [DEGREE_W-1:0]       DEGREE_RESET = 4'd1;
  localparam logic signed [VALUE_W-1:0] Q_ONE        = 16'sd16384;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX    = 16'sh7fff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN    = 16'sh8000;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_MUL,
    ST_SUM,
    ST_LAUNCH,
    ST_WAIT
  } lpe_state_t;

  // Request into the division chain
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        divisor;
  } lpe_div_req_t;

  // Saturated quotient out of the division chain
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } lpe_div_rsp_t;

  // Link between neighboring division stages
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  den;
    logic [QUOT_W-1:0] quot;
  } lpe_link_t;

endpackage

[design/lpe_div_cell.sv]
// ---------------------------------------------------------------------------
// Division stage
// Retires one quotient bit by restoring subtraction and hands the partial
// remainder, the halved divisor and the quotient so far to its neighbor.
// ---------------------------------------------------------------------------
module lpe_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lpe_pkg::lpe_link_t stage_i,
  output lpe_pkg::lpe_link_t stage_o
);

  lpe_pkg::lpe_link_t stage_r;
  lpe_pkg::lpe_link_t stage_nxt;

  // Subtract when the shifted divisor fits, shift the quotient bit in
  always_comb begin
    stage_nxt     = stage_i;
    stage_nxt.den = stage_i.den >> 1;
    if (stage_i.rem >= stage_i.den) begin
      stage_nxt.rem  = stage_i.rem - stage_i.den;
      stage_nxt.quot = {stage_i.quot[lpe_pkg::QUOT_W-2:0], 1'b1};
    end else begin
      stage_nxt.quot = {stage_i.quot[lpe_pkg::QUOT_W-2:0], 1'b0};
    end
  end

  // Advance; clear the stage on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

[design/lpe_div_chain.sv]
// ---------------------------------------------------------------------------
// Division chain
// Signed sum divided by a small index, truncated toward zero and saturated
// to 16 bits, through a row of one-bit restoring division stages.
// ---------------------------------------------------------------------------
module lpe_div_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpe_pkg::lpe_div_req_t req_i,
  output lpe_pkg::lpe_div_rsp_t rsp_o
);

  localparam int unsigned NSTG = lpe_pkg::QUOT_W;

  lpe_pkg::lpe_link_t              link [NSTG+1];
  lpe_pkg::lpe_link_t              head;
  logic [lpe_pkg::SUM_W-1:0]       mag;
  logic [lpe_pkg::REM_W-1:0]       limit;
  logic                            sat;
  logic [lpe_pkg::VALUE_W-1:0]     quot_ext;
  lpe_pkg::lpe_link_t              tail;

  // Take the magnitude and flag quotients that cannot fit in 15 bits
  always_comb begin
    mag   = req_i.sum[lpe_pkg::SUM_W-1] ? lpe_pkg::SUM_W'(-req_i.sum)
                                        : lpe_pkg::SUM_W'(req_i.sum);
    limit = lpe_pkg::REM_W'({req_i.divisor, {lpe_pkg::QUOT_W{1'b0}}});
    sat   = (mag >= lpe_pkg::SUM_W'(limit));

    head.valid = req_i.valid;
    head.neg   = req_i.sum[lpe_pkg::SUM_W-1];
    head.sat   = sat;
    head.rem   = sat ? '0 : mag[lpe_pkg::REM_W-1:0];
    head.den   = lpe_pkg::REM_W'({req_i.divisor, {(lpe_pkg::QUOT_W-1){1'b0}}});
    head.quot  = '0;
  end

  assign link[0] = head;

  // Row of stages, one quotient bit each
  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    lpe_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (link[j]),
      .stage_o (link[j+1])
    );
  end

  // Apply sign and saturation at the end of the row
  always_comb begin
    tail        = link[NSTG];
    quot_ext    = {1'b0, tail.quot};
    rsp_o.valid = tail.valid;
    if (tail.sat) begin
      rsp_o.value = tail.neg ? lpe_pkg::VALUE_MIN : lpe_pkg::VALUE_MAX;
    end else if (tail.neg) begin
      rsp_o.value = -$signed(quot_ext);
    end else begin
      rsp_o.value = $signed(quot_ext);
    end
  end

endmodule

[design/legendre_polynomial_eval.sv]
// ---------------------------------------------------------------------------
// Legendre polynomial evaluator
// For each point x (signed Q2.14) emits P0..Pd at x, one item per degree,
// in index order, tlast on Pd; d is the degree register (reset 1).
// ---------------------------------------------------------------------------
// One point is worked on at a time. P0 and P1 are emitted directly; every
// higher degree passes through the x*P product, the recurrence sum, the
// division launch and the division chain (one quotient bit per stage),
// after which the value is emitted once the output register is free. A
// result waiting in the output register does not block acceptance of the
// next point.
// ---------------------------------------------------------------------------
module legendre_polynomial_eval (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: degree
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] point
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] poly_value
  output logic [3:0]  out_tuser,   // [3:0] poly_index
  output logic        out_tlast
);

  lpe_pkg::lpe_state_t state_r, state_nxt;

  logic [lpe_pkg::DEGREE_W-1:0]       degree_r, degree_nxt;
  logic [lpe_pkg::DEGREE_W-1:0]       dlim_r, dlim_nxt;
  logic [lpe_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [lpe_pkg::POINT_W-1:0] x_r, x_nxt;
  logic signed [lpe_pkg::VALUE_W-1:0] prev_r, prev_nxt;
  logic signed [lpe_pkg::VALUE_W-1:0] cur_r, cur_nxt;
  logic signed [lpe_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [lpe_pkg::SUM_W-1:0]   sum_r, sum_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [lpe_pkg::VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic [lpe_pkg::IDX_W-1:0]          out_index_r, out_index_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               slot_free;
  logic [lpe_pkg::IDX_W-1:0]          k;
  logic signed [31:0]                 prod_full;
  logic signed [5:0]                  coef_a;
  logic signed [4:0]                  coef_b;
  logic signed [lpe_pkg::SUM_W-1:0]   term_a;
  logic signed [lpe_pkg::SUM_W-1:0]   term_b;

  lpe_pkg::lpe_div_req_t              div_req;
  lpe_pkg::lpe_div_rsp_t              div_rsp;

  // Recurrence arithmetic for P(idx) with k = idx - 1
  always_comb begin
    k         = idx_r - 1'b1;
    prod_full = x_r * cur_r;
    coef_a    = $signed({1'b0, k, 1'b1});
    coef_b    = $signed({1'b0, k});
    term_a    = coef_a * prod_r;
    term_b    = coef_b * prev_r;
  end

  assign slot_free = !out_valid_r || out_tready;

  // Division request comes straight from the sum register
  always_comb begin
    div_req.valid   = (state_r == lpe_pkg::ST_LAUNCH);
    div_req.sum     = sum_r;
    div_req.divisor = idx_r;
  end

  lpe_div_chain u_div_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Controller: next state and datapath loads
  always_comb begin
    state_nxt     = state_r;
    degree_nxt    = degree_r;
    dlim_nxt      = dlim_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      degree_nxt = cfg_wr_data;
    end

    // Drop the held item once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lpe_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = $signed(in_tdata);
          prev_nxt  = lpe_pkg::Q_ONE;
          cur_nxt   = $signed(in_tdata);
          idx_nxt   = '0;
          dlim_nxt  = (degree_r > lpe_pkg::MAX_DEGREE) ? lpe_pkg::MAX_DEGREE : degree_r;
          state_nxt = lpe_pkg::ST_EMIT;
        end
      end
      lpe_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (idx_r == '0) ? lpe_pkg::Q_ONE : cur_r;
          out_index_nxt = idx_r;
          out_last_nxt  = (idx_r == dlim_r);
          if (idx_r == dlim_r) begin
            state_nxt = lpe_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = (idx_r == '0) ? lpe_pkg::ST_EMIT : lpe_pkg::ST_MUL;
          end
        end
      end
      lpe_pkg::ST_MUL: begin
        prod_nxt  = prod_full[31:lpe_pkg::Q_SHIFT];
        state_nxt = lpe_pkg::ST_SUM;
      end
      lpe_pkg::ST_SUM: begin
        sum_nxt   = term_a - term_b;
        state_nxt = lpe_pkg::ST_LAUNCH;
      end
      lpe_pkg::ST_LAUNCH: begin
        state_nxt = lpe_pkg::ST_WAIT;
      end
      lpe_pkg::ST_WAIT: begin
        if (div_rsp.valid) begin
          prev_nxt  = cur_r;
          cur_nxt   = div_rsp.value;
          state_nxt = lpe_pkg::ST_EMIT;
        end
      end
      default: begin
        state_nxt = lpe_pkg::ST_IDLE;
      end
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpe_pkg::ST_IDLE;
      degree_r    <= lpe_pkg::DEGREE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      degree_r    <= degree_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dlim_r      <= dlim_nxt;
    idx_r       <= idx_nxt;
    x_r         <= x_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    prod_r      <= prod_nxt;
    sum_r       <= sum_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == lpe_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_index_r;
  assign out_tlast  = out_last_r;

endmodule

[design/lpe_checker.sv]
// ---------------------------------------------------------------------------
// Legendre polynomial evaluator port checker
// Watches the stream ports for index order, P0 value, busy behavior and stalled items.
// ---------------------------------------------------------------------------
`include "legendre_polynomial_eval_assert.svh"

module lpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [3:0]  out_tuser,
  input logic        out_tlast
);

  logic [3:0] exp_idx_r;
  logic [3:0] exp_idx_nxt;
  logic       out_fire;
  logic       in_fire;

  assign out_fire = out_tvalid && out_tready;
  assign in_fire  = in_tvalid && in_tready;

  // Track the index the next item must carry
  always_comb begin
    exp_idx_nxt = exp_idx_r;
    if (out_fire) begin
      exp_idx_nxt = out_tlast ? 4'd0 : exp_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= 4'd0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
    end
  end

  `LPE_ASSERT_NOW(a_index_order, out_tvalid, out_tuser == exp_idx_r, "item index out of order")
  `LPE_ASSERT_NOW(a_p0_value, out_tvalid && out_tuser == 4'd0, out_tdata == 16'd16384, "P0 not 1.0")
  `LPE_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "point taken while busy")
  `LPE_ASSERT_NEXT(a_hold_stalled, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled item changed")

endmodule

bind legendre_polynomial_eval lpe_checker u_lpe_checker (.*);

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// Legendre polynomial evaluator testbench
// Streams points into the evaluator under several degree settings and idle
// patterns, predicts P0..Pd for every accepted point with the fixed-point
// three-term recurrence, and compares each result item in order.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lpe_pkg::*;

  // One expected result item
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          index;
    logic                      last;
  } poly_term_t;

  // Holds the expected polynomial values of accepted points, oldest first
  class legendre_scoreboard;
    poly_term_t terms[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Run the recurrence for one point and queue P0..Pd
    function void note_point(logic signed [POINT_W-1:0] x, logic [DEGREE_W-1:0] deg);
      longint     xs;
      longint     prev;
      longint     cur;
      longint     v;
      longint     k;
      longint     prod;
      longint     acc;
      int         top;
      poly_term_t t;
      xs   = x;
      prev = Q_ONE;
      cur  = xs;
      top  = (deg > MAX_DEGREE) ? int'(MAX_DEGREE) : int'(deg);
      for (int i = 0; i <= top; i++) begin
        if (i == 0) begin
          v = Q_ONE;
        end else if (i == 1) begin
          v = xs;
        end else begin
          k    = i - 1;
          prod = (xs * cur) >>> Q_SHIFT;
          acc  = (2 * k + 1) * prod - k * prev;
          // SystemVerilog division truncates toward zero
          v = acc / (k + 1);
          if (v > longint'(VALUE_MAX)) v = VALUE_MAX;
          if (v < longint'(VALUE_MIN)) v = VALUE_MIN;
          prev = cur;
          cur  = v;
        end
        t.value = v[VALUE_W-1:0];
        t.index = i[IDX_W-1:0];
        t.last  = (i == top);
        terms.push_back(t);
      end
    endfunction

    // Compare one result item with the oldest expectation
    function void check_term(logic signed [VALUE_W-1:0] value, logic [IDX_W-1:0] index,
                             logic last);
      poly_term_t t;
      if (terms.size() == 0) begin
        errors++;
        $display("%0t: unexpected item value=%0d index=%0d last=%0b",
                 $time, value, index, last);
        return;
      end
      t = terms.pop_front();
      if (value !== t.value || index !== t.index || last !== t.last) begin
        errors++;
        $display("%0t: mismatch expected value=%0d index=%0d last=%0b,",
                 $time, t.value, t.index, t.last,
                 " actual value=%0d index=%0d last=%0b", value, index, last);
      end
    endfunction

    function int pending();
      return terms.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = 4'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;    // [15:0] point
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [15:0] poly_value
  logic [3:0]  out_tuser;           // [3:0] poly_index
  logic        out_tlast;

  legendre_scoreboard   poly_sb = new();
  logic [DEGREE_W-1:0]  poly_degree = DEGREE_RESET;
  int                   in_idle_pct = 0;
  int                   out_stall_pct = 0;
  int                   phase_degree [8] = '{15, 0, 4, 15, 1, -1, 9, -1};
  logic signed [15:0]   corner_points [10] =
    '{16'sd16384, -16'sd16384, 16'sd0, 16'sh7fff, 16'sh8000,
      16'sd1, -16'sd1, 16'sd8192, 16'sh5555, -16'sd11586};

  legendre_polynomial_eval u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Note every accepted point with the degree in force
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) poly_sb.note_point(in_tdata, poly_degree);
  end

  // Check every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) poly_sb.check_term(out_tdata, out_tuser, out_tlast);
  end

  // Mostly points on [-1,1], some corners, some anywhere in 16 bits
  function automatic logic [15:0] random_point();
    int r;
    r = $urandom_range(99);
    if (r < 78) return 16'($urandom_range(32768)) - 16'd16384;
    if (r < 88) begin
      case ($urandom_range(4))
        0:       return 16'sd16384;
        1:       return -16'sd16384;
        2:       return 16'sd0;
        3:       return 16'sh7fff;
        default: return 16'sh8000;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Offer one point, idling first at random, and hold until accepted
  task automatic send_point(input logic [15:0] x);
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Write the degree register; only called while nothing is in flight
  task automatic load_degree(input logic [DEGREE_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    poly_degree = d;
  endtask

  // Drop valid and wait until every expected item has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (poly_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner points at the highest degree
    load_degree(4'd15);
    foreach (corner_points[i]) send_point(corner_points[i]);
    drain_results();

    // Degree zero: P0 only, with last set
    load_degree(4'd0);
    send_point(16'sd16384);
    send_point(16'sh8000);
    send_point(16'sh7fff);
    drain_results();

    // Degree one and two
    load_degree(4'd1);
    send_point(16'sd12345);
    send_point(-16'sd16384);
    send_point(16'sh8000);
    drain_results();
    load_degree(4'd2);
    send_point(-16'sd16384);
    send_point(16'sd12000);
    drain_results();

    // Random phases over the idle patterns and several degrees
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 53; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 53; end
        default: begin in_idle_pct = 26; out_stall_pct = 26; end
      endcase
      if (phase_degree[p] < 0) load_degree(4'($urandom_range(15)));
      else load_degree(4'(phase_degree[p]));
      repeat (60) send_point(random_point());
      drain_results();
    end

    repeat (300) @(posedge clk);
    if (poly_sb.errors == 0 && poly_sb.pending() == 0) begin
      $display("legendre_polynomial_eval regression: pass");
    end else begin
      $display("legendre_polynomial_eval regression: fail");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #8_000_000;
    $display("legendre_polynomial_eval regression: fail");
    $finish;
  end

endmodule
